FILE: rtl/rrbc_pkg.sv
// Types and constants shared by the ROM/RAM bank controller.
`default_nettype none
package rrbc_pkg;

  localparam int unsigned ROM_OFS_W  = 14;  // offset inside one ROM bank
  localparam int unsigned RAM_OFS_W  = 13;  // offset inside the RAM window
  localparam int unsigned ROM_BANK_W = 7;
  localparam int unsigned LOW_BANK_W = 5;
  localparam int unsigned UP_BANK_W  = 2;
  localparam int unsigned ROM_ADDR_W = ROM_BANK_W + ROM_OFS_W;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [3:0] RAM_EN_KEY   = 4'hA;
  localparam logic [7:0] RAM_OFF_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    OP_ROM_READ  = 2'd0,
    OP_REG_WRITE = 2'd1,
    OP_RAM_READ  = 2'd2,
    OP_RAM_WRITE = 2'd3
  } opcode_t;

  // Register selected by address bits 14..13 of a ROM-space write
  typedef enum logic [1:0] {
    REG_RAM_ENABLE = 2'd0,
    REG_LOW_BANK   = 2'd1,
    REG_UPPER_BANK = 2'd2,
    REG_MODE       = 2'd3
  } bank_reg_t;

  // Configuration register indexes (paddr bit 2)
  typedef enum logic {
    CFG_ROM_MASK = 1'b0,
    CFG_RAM_MASK = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [14:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [20:0] rom_address;
    logic        from_rom;
  } out_result_t;

  // Access control from the bank logic to the datapath
  typedef struct packed {
    logic ram_we;      // RAM write, enable already applied
    logic ram_re;      // RAM read beat
    logic rom_re;      // ROM read beat
    logic ram_enable;  // RAM enable at the time of the access
  } access_t;

endpackage
`default_nettype wire

FILE: rtl/rrbc_ram.sv
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module rrbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

FILE: rtl/rrbc_bank_ctrl.sv
// Bank registers, register-write decode and ROM/RAM address generation.
`default_nettype none
module rrbc_bank_ctrl #(
  parameter int unsigned RAM_BANKS = 4,
  parameter int unsigned RAM_AW    = 15
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             accept,
  input  wire rrbc_pkg::in_item_t               item,
  input  wire logic [rrbc_pkg::ROM_BANK_W-1:0]  rom_bank_mask,
  input  wire logic [rrbc_pkg::UP_BANK_W-1:0]   ram_bank_mask,
  output rrbc_pkg::access_t                     access,
  output logic      [RAM_AW-1:0]                ram_addr,
  output logic      [rrbc_pkg::ROM_ADDR_W-1:0]  rom_address
);

  localparam int unsigned BANK_W = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;
  localparam logic [2:0]  NBANKS = 3'(RAM_BANKS);

  logic                               ram_enable_r, ram_enable_nxt;
  logic [rrbc_pkg::LOW_BANK_W-1:0]    low_bank_r, low_bank_nxt;
  logic [rrbc_pkg::UP_BANK_W-1:0]     upper_bank_r, upper_bank_nxt;
  logic                               mode_r, mode_nxt;

  rrbc_pkg::opcode_t                  op;
  logic [rrbc_pkg::ROM_BANK_W-1:0]    rom_bank;
  logic [2:0]                         ram_bank_mod;
  logic [BANK_W+rrbc_pkg::RAM_OFS_W-1:0] ram_idx;

  assign op = rrbc_pkg::opcode_t'(item.opcode);

  // Register writes
  always_comb begin
    ram_enable_nxt = ram_enable_r;
    low_bank_nxt   = low_bank_r;
    upper_bank_nxt = upper_bank_r;
    mode_nxt       = mode_r;
    if (accept && op == rrbc_pkg::OP_REG_WRITE) begin
      unique case (rrbc_pkg::bank_reg_t'(item.address[14:13]))
        rrbc_pkg::REG_RAM_ENABLE: begin
          ram_enable_nxt = (item.write_data[3:0] == rrbc_pkg::RAM_EN_KEY);
        end
        rrbc_pkg::REG_LOW_BANK: begin
          low_bank_nxt = (item.write_data[4:0] == '0) ?
                         rrbc_pkg::LOW_BANK_W'(1) : item.write_data[4:0];
        end
        rrbc_pkg::REG_UPPER_BANK: begin
          upper_bank_nxt = item.write_data[1:0];
        end
        rrbc_pkg::REG_MODE: begin
          mode_nxt = item.write_data[0];
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_enable_r <= 1'b0;
      low_bank_r   <= rrbc_pkg::LOW_BANK_W'(1);
      upper_bank_r <= '0;
      mode_r       <= 1'b0;
    end else begin
      ram_enable_r <= ram_enable_nxt;
      low_bank_r   <= low_bank_nxt;
      upper_bank_r <= upper_bank_nxt;
      mode_r       <= mode_nxt;
    end
  end

  // ROM address: the upper window's offset is simply the low 14 bits
  always_comb begin
    if (item.address[14]) begin
      rom_bank = {upper_bank_r, low_bank_r};
    end else if (mode_r) begin
      rom_bank = {upper_bank_r, rrbc_pkg::LOW_BANK_W'(0)};
    end else begin
      rom_bank = '0;
    end
    rom_bank    = rom_bank & rom_bank_mask;
    rom_address = {rom_bank, item.address[rrbc_pkg::ROM_OFS_W-1:0]};
  end

  // RAM bank folded into the bank count; value is below 4, so three steps suffice
  always_comb begin
    ram_bank_mod = mode_r ? {1'b0, upper_bank_r & ram_bank_mask} : 3'd0;
    for (int k = 0; k < 3; k++) begin
      if (ram_bank_mod >= NBANKS) begin
        ram_bank_mod = ram_bank_mod - NBANKS;
      end
    end
    ram_idx  = {ram_bank_mod[BANK_W-1:0], item.address[rrbc_pkg::RAM_OFS_W-1:0]};
    ram_addr = ram_idx[RAM_AW-1:0];
  end

  always_comb begin
    access.ram_we     = accept && op == rrbc_pkg::OP_RAM_WRITE && ram_enable_r;
    access.ram_re     = accept && op == rrbc_pkg::OP_RAM_READ;
    access.rom_re     = accept && op == rrbc_pkg::OP_ROM_READ;
    access.ram_enable = ram_enable_r;
  end

endmodule
`default_nettype wire

FILE: rtl/rom_ram_bank_controller_top.sv
// Top level of the ROM/RAM bank controller.
`default_nettype none
// Cartridge bank controller. One bus access is taken per clock (start high,
// busy is never raised). Register writes and RAM writes take effect at the
// accepting edge, so the very next access sees them. ROM-space reads and
// RAM reads give one result beat on the cycle after acceptance, marked by
// out_valid for that single cycle; the latency is set by the registered read
// port of the cartridge RAM. The receiver cannot stall and must take every
// result beat as it appears. ROM-space writes and RAM writes produce no
// result. Cartridge RAM has no reset: reading a byte never written returns
// an undefined value. The APB port (pready always high) holds the ROM bank
// mask at 0x0 and the RAM bank mask at 0x4; change them only while no
// access is in flight.
module rom_ram_bank_controller_top #(
  parameter int unsigned RAM_BANKS = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // command channel
  input  wire logic                              start,
  output logic                                   busy,
  input  wire rrbc_pkg::in_item_t                in_item,
  // result channel
  output logic                                   out_valid,
  output rrbc_pkg::out_result_t                  out_result,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [rrbc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [rrbc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [rrbc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                   pready
);

  localparam int unsigned RAM_DEPTH = RAM_BANKS * 8192;
  localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);

  logic                                accept;
  rrbc_pkg::access_t                   access;
  logic [RAM_AW-1:0]                   ram_addr;
  logic [rrbc_pkg::ROM_ADDR_W-1:0]     rom_address;
  logic [7:0]                          ram_rdata;

  logic [rrbc_pkg::ROM_BANK_W-1:0]     rom_mask_r;
  logic [rrbc_pkg::UP_BANK_W-1:0]      ram_mask_r;
  logic                                cfg_wr;

  logic                                out_valid_r;
  logic                                out_from_rom_r;
  logic                                out_ram_en_r;
  logic [rrbc_pkg::ROM_ADDR_W-1:0]     out_rom_addr_r;

  // Every beat is accepted as it arrives; busy is never raised
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---- configuration port ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_mask_r <= rrbc_pkg::ROM_BANK_W'(1);
      ram_mask_r <= '0;
    end else if (cfg_wr) begin
      unique case (rrbc_pkg::cfg_reg_t'(paddr[2]))
        rrbc_pkg::CFG_ROM_MASK: rom_mask_r <= pwdata[rrbc_pkg::ROM_BANK_W-1:0];
        rrbc_pkg::CFG_RAM_MASK: ram_mask_r <= pwdata[rrbc_pkg::UP_BANK_W-1:0];
        default:                rom_mask_r <= rom_mask_r;
      endcase
    end
  end

  always_comb begin
    unique case (rrbc_pkg::cfg_reg_t'(paddr[2]))
      rrbc_pkg::CFG_ROM_MASK:
        prdata = {{(rrbc_pkg::CFG_DATA_W-rrbc_pkg::ROM_BANK_W){1'b0}}, rom_mask_r};
      rrbc_pkg::CFG_RAM_MASK:
        prdata = {{(rrbc_pkg::CFG_DATA_W-rrbc_pkg::UP_BANK_W){1'b0}}, ram_mask_r};
      default:
        prdata = '0;
    endcase
  end

  // ---- bank registers and address generation ----
  rrbc_bank_ctrl #(
    .RAM_BANKS (RAM_BANKS),
    .RAM_AW    (RAM_AW)
  ) u_bank_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .item          (in_item),
    .rom_bank_mask (rom_mask_r),
    .ram_bank_mask (ram_mask_r),
    .access        (access),
    .ram_addr      (ram_addr),
    .rom_address   (rom_address)
  );

  // ---- cartridge RAM; a write followed by a read of the same byte in the
  // next cycle is safe since the write lands before the read is issued ----
  rrbc_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (access.ram_we),
    .addr  (ram_addr),
    .wdata (in_item.write_data),
    .rdata (ram_rdata)
  );

  // ---- result stage, aligned with the RAM read latency ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= access.ram_re || access.rom_re;
    end
  end

  always_ff @(posedge clk) begin
    if (access.ram_re || access.rom_re) begin
      out_from_rom_r <= access.rom_re;
      out_ram_en_r   <= access.ram_enable;
      out_rom_addr_r <= rom_address;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    out_result.from_rom = out_from_rom_r;
    if (out_from_rom_r) begin
      out_result.read_data   = '0;
      out_result.rom_address = out_rom_addr_r;
    end else begin
      out_result.read_data   = out_ram_en_r ? ram_rdata : rrbc_pkg::RAM_OFF_BYTE;
      out_result.rom_address = '0;
    end
  end

endmodule
`default_nettype wire
